@@ hw/rtl/ddo_pkg.sv @@
package ddo_pkg;

    localparam int CordicSteps = 24;
    localparam int StepW = $clog2(CordicSteps + 1);

    localparam logic signed [33:0] GainQ30 = 34'sd652032874;

    localparam logic [2:0] RegDistPerTick = 3'd0;
    localparam logic [2:0] RegAnglePerTick = 3'd1;
    localparam logic [2:0] RegGoalX = 3'd2;
    localparam logic [2:0] RegGoalY = 3'd3;
    localparam logic [2:0] RegStopDist = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQS,
        ST_DEC,
        ST_HALF,
        ST_CORDIC,
        ST_MULX,
        ST_MULY,
        ST_HEAD,
        ST_OUT
    } state_t;

    // multiplier operation codes
    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_HALF,
        MUL_AXIS,
        MUL_HEAD
    } mul_op_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0: t = 32'd536870912;
            5'd1: t = 32'd316933406;
            5'd2: t = 32'd167458907;
            5'd3: t = 32'd85004756;
            5'd4: t = 32'd42667331;
            5'd5: t = 32'd21354465;
            5'd6: t = 32'd10679838;
            5'd7: t = 32'd5340245;
            5'd8: t = 32'd2670163;
            5'd9: t = 32'd1335087;
            5'd10: t = 32'd667544;
            5'd11: t = 32'd333772;
            5'd12: t = 32'd166886;
            5'd13: t = 32'd83443;
            5'd14: t = 32'd41722;
            5'd15: t = 32'd20861;
            5'd16: t = 32'd10430;
            5'd17: t = 32'd5215;
            5'd18: t = 32'd2608;
            5'd19: t = 32'd1304;
            5'd20: t = 32'd652;
            5'd21: t = 32'd326;
            5'd22: t = 32'd163;
            5'd23: t = 32'd81;
            5'd24: t = 32'd41;
            5'd25: t = 32'd20;
            5'd26: t = 32'd10;
            5'd27: t = 32'd5;
            5'd28: t = 32'd3;
            5'd29: t = 32'd1;
            5'd30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

@@ hw/rtl/ddo_cordic.sv @@
module ddo_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);

    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [ddo_pkg::StepW-1:0] step_reg;
    logic busy_reg, neg_reg;
    logic signed [33:0] tx, ty;
    logic [31:0] at;
    logic [31:0] h;
    logic neg;

    assign neg = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    assign h = neg ? angle - 32'h8000_0000 : angle;
    assign tx = x_reg >>> step_reg;
    assign ty = y_reg >>> step_reg;
    assign at = ddo_pkg::atan_turn(5'(step_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg <= ddo_pkg::GainQ30;
                y_reg <= '0;
                z_reg <= {h[31], h};
                neg_reg <= neg;
            end else if (busy_reg) begin
                if (!z_reg[32]) begin
                    x_reg <= x_reg - ty;
                    y_reg <= y_reg + tx;
                    z_reg <= z_reg - $signed({1'b0, at});
                end else begin
                    x_reg <= x_reg + ty;
                    y_reg <= y_reg - tx;
                    z_reg <= z_reg + $signed({1'b0, at});
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1)) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

@@ hw/rtl/diff_drive_odometry_goal_check.sv @@
// Channel  | Dir | tdata fields (low bit first)
// s_axis   | in  | right_count[31:0], left_count[31:0]
// m_axis   | out | x_position, y_position, heading (96b); tuser = at_goal
// cfg      | in  | wr_en, wr_index, wr_data[31:0]
// Near goal an item goes from the distance test to output; otherwise it runs travel, 24 CORDIC steps, pose updates.
// One shared signed 34x34 multiplier does squares, travel, axis steps and heading.
// Reset: synchronous active-low aresetn; pose and last counts clear, goal to defaults.
// s_tready is low from accept until the result transfer; output holds under stall.
module diff_drive_odometry_goal_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // right_count, left_count
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // x_position, y_position, heading
    output logic         m_tuser,   // at_goal
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data
);

    ddo_pkg::state_t state_reg, state_next;

    logic [23:0] dist_reg;
    logic [31:0] ang_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic [30:0] stop_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0] head_reg, lr_reg, ll_reg, rc_reg, lc_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [63:0] acc_reg;
    logic signed [33:0] half_reg;
    logic at_goal_reg;
    logic head_pend_reg;

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [67:0] prod_reg;
    assign prod = ma * mb;

    logic cstart, cdone;
    logic signed [33:0] cosv, sinv;

    ddo_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .angle(head_reg),
        .done(cdone), .cos_out(cosv), .sin_out(sinv)
    );

    logic [31:0] dr, dl;
    assign dr = rc_reg - lr_reg;
    assign dl = lc_reg - ll_reg;
    logic signed [33:0] sum;
    assign sum = 34'(signed'(dr)) + 34'(signed'(dl));

    logic far;
    assign far = (dx_reg > 33'sd2147483647) || (dx_reg < -33'sd2147483647)
              || (dy_reg > 33'sd2147483647) || (dy_reg < -33'sd2147483647);

    function automatic logic signed [31:0] sat(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7fff_ffff;
        if (v < -68'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    logic signed [67:0] half_full, axis_shift, xs, ys;
    assign half_full = prod_reg >>> 9;
    assign axis_shift = prod_reg >>> 30;
    assign xs = 68'(x_reg) + axis_shift;
    assign ys = 68'(y_reg) + axis_shift;

    logic [31:0] head_out;
    assign head_out = head_pend_reg ? head_reg + prod_reg[31:0] : head_reg;

    always_comb begin
        state_next = state_reg;
        cstart = 1'b0;
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE: if (s_tvalid) state_next = ddo_pkg::ST_SQX;
            ddo_pkg::ST_SQX: begin
                ma = 34'(dx_reg); mb = 34'(dx_reg); state_next = ddo_pkg::ST_SQY;
            end
            ddo_pkg::ST_SQY: begin
                ma = 34'(dy_reg); mb = 34'(dy_reg); state_next = ddo_pkg::ST_SQS;
            end
            ddo_pkg::ST_SQS: begin
                ma = 34'({1'b0, stop_reg}); mb = 34'({1'b0, stop_reg});
                state_next = ddo_pkg::ST_DEC;
            end
            ddo_pkg::ST_DEC: begin
                if (!far && acc_reg < prod_reg[63:0]) state_next = ddo_pkg::ST_OUT;
                else begin
                    ma = sum; mb = 34'({10'd0, dist_reg});
                    cstart = 1'b1;
                    state_next = ddo_pkg::ST_HALF;
                end
            end
            ddo_pkg::ST_HALF: state_next = ddo_pkg::ST_CORDIC;
            ddo_pkg::ST_CORDIC: if (cdone) state_next = ddo_pkg::ST_MULX;
            ddo_pkg::ST_MULX: begin
                ma = half_reg; mb = cosv; state_next = ddo_pkg::ST_MULY;
            end
            ddo_pkg::ST_MULY: begin
                ma = half_reg; mb = sinv; state_next = ddo_pkg::ST_HEAD;
            end
            ddo_pkg::ST_HEAD: begin
                ma = 34'(dr - dl); mb = 34'(ang_reg); state_next = ddo_pkg::ST_OUT;
            end
            ddo_pkg::ST_OUT: if (m_tready && !head_pend_reg) state_next = ddo_pkg::ST_IDLE;
            default: state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddo_pkg::ST_IDLE;
            dist_reg <= '0;
            ang_reg <= '0;
            gx_reg <= 32'sd45875;
            gy_reg <= 32'sd52429;
            stop_reg <= 31'd3277;
            x_reg <= '0;
            y_reg <= '0;
            head_reg <= '0;
            lr_reg <= '0;
            ll_reg <= '0;
        end else begin
            state_reg <= state_next;
            prod_reg <= prod;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    ddo_pkg::RegDistPerTick: dist_reg <= cfg_wr_data[23:0];
                    ddo_pkg::RegAnglePerTick: ang_reg <= cfg_wr_data;
                    ddo_pkg::RegGoalX: gx_reg <= cfg_wr_data;
                    ddo_pkg::RegGoalY: gy_reg <= cfg_wr_data;
                    ddo_pkg::RegStopDist: stop_reg <= cfg_wr_data[30:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ddo_pkg::ST_IDLE: if (s_tvalid) begin
                    rc_reg <= s_tdata[31:0];
                    lc_reg <= s_tdata[63:32];
                    dx_reg <= 33'(x_reg) - 33'(gx_reg);
                    dy_reg <= 33'(y_reg) - 33'(gy_reg);
                end
                ddo_pkg::ST_SQY: acc_reg <= prod_reg[63:0];
                ddo_pkg::ST_SQS: acc_reg <= acc_reg + prod_reg[63:0];
                ddo_pkg::ST_DEC: at_goal_reg <= !far && acc_reg < prod_reg[63:0];
                ddo_pkg::ST_HALF: half_reg <= 34'(sat(half_full));
                ddo_pkg::ST_MULY: x_reg <= sat(xs);
                ddo_pkg::ST_HEAD: y_reg <= sat(ys);
                default: ;
            endcase
            if (state_reg == ddo_pkg::ST_HEAD) begin
                lr_reg <= rc_reg;
                ll_reg <= lc_reg;
            end
            if (head_pend_reg) head_reg <= head_out;
        end
    end

    // heading add after head multiply lands in prod_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) head_pend_reg <= 1'b0;
        else begin
            head_pend_reg <= (state_reg == ddo_pkg::ST_HEAD);
        end
    end

    assign s_tready = (state_reg == ddo_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == ddo_pkg::ST_OUT) && !head_pend_reg;
    assign m_tdata = {head_reg, y_reg, x_reg};
    assign m_tuser = at_goal_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_goal_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> $stable(x_reg)) else $error("pose moved at goal");
    a_cordic_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cstart |=> state_reg == ddo_pkg::ST_HALF) else $error("cordic start misplaced");
`endif

endmodule
